// File: rtl/core/fbcl_pkg.sv
// ============================================================================
// fbcl_pkg: shared types and constants for the frustum cull and LOD block
// Field widths, stream packing offsets, the controller state encoding and
// the command and status bundles between the controller and the datapath.
// ============================================================================
`default_nettype none

package fbcl_pkg;

    // Field widths.
    localparam int SIZE_W  = 23;   // chunk edge length, unsigned Q15.8
    localparam int COORD_W = 16;   // chunk grid coordinate
    localparam int POS_W   = 24;   // camera position, signed Q16.8
    localparam int NRM_W   = 16;   // normal component, signed Q2.14
    localparam int OFF_W   = 24;   // plane constant, signed Q16.8
    localparam int IDX_W   = 3;    // plane index field
    localparam int LOD_W   = 2;

    // Internal widths.
    localparam int MIN_W   = 39;   // coord * size and coord * size + size
    localparam int DIFF_W  = 40;   // camera minus chunk corner
    localparam int ABS_W   = 39;   // magnitude of that difference
    localparam int NEAR_W  = 25;   // width of 4 * size
    localparam int MUL_W   = 26;   // signed operand width of the shared multiplier
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SS_W    = 2 * SIZE_W;
    localparam int D2_W    = 2 * NEAR_W + 1;
    localparam int ACC_W   = 56;   // plane distance in Q.22
    localparam int SPLIT   = 20;   // low part of a box coordinate per multiply
    localparam int BOX_TOP_SH = 13; // box top 32.0 in Q16.8 is 1 << 13
    localparam int OFF_SH  = 14;   // Q16.8 offset to Q.22

    localparam logic [SIZE_W-1:0] SIZE_RESET = 23'd16384;

    // Stream packing.
    localparam int IN_TDATA_W  = 160;
    localparam int OUT_TDATA_W = 8;
    localparam int F_IDX_LSB  = 0;
    localparam int F_NX_LSB   = F_IDX_LSB + IDX_W;
    localparam int F_NY_LSB   = F_NX_LSB + NRM_W;
    localparam int F_NZ_LSB   = F_NY_LSB + NRM_W;
    localparam int F_OFF_LSB  = F_NZ_LSB + NRM_W;
    localparam int F_CX_LSB   = F_OFF_LSB + OFF_W;
    localparam int F_CZ_LSB   = F_CX_LSB + COORD_W;
    localparam int F_CAMX_LSB = F_CZ_LSB + COORD_W;
    localparam int F_CAMZ_LSB = F_CAMX_LSB + POS_W;
    localparam int F_UPD_LSB  = F_CAMZ_LSB + POS_W;

    // Operation codes carried in tuser.
    localparam logic OP_TEST = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Detail levels.
    localparam logic [LOD_W-1:0] LOD_NEAR = 2'd0;
    localparam logic [LOD_W-1:0] LOD_MID  = 2'd1;
    localparam logic [LOD_W-1:0] LOD_FAR  = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MINX,
        ST_MINZ,
        ST_SS,
        ST_DIFF,
        ST_ABS,
        ST_DX2,
        ST_DZ2,
        ST_D2,
        ST_LOD,
        ST_PL_XL,
        ST_PL_XH,
        ST_PL_ZL,
        ST_PL_ZH,
        ST_PL_END,
        ST_PL_CHK,
        ST_DONE
    } t_state;

    // Operand pair steered into the shared multiplier.
    typedef enum logic [3:0] {
        MS_NONE,
        MS_CXS,
        MS_CZS,
        MS_SS,
        MS_DX2,
        MS_DZ2,
        MS_XL,
        MS_XH,
        MS_ZL,
        MS_ZH
    } t_mul_sel;

    // Where the registered product goes.
    typedef enum logic [2:0] {
        PD_NONE,
        PD_MINX,
        PD_MINZ,
        PD_SS,
        PD_D2_SET,
        PD_D2_ADD,
        PD_ACC_LO,
        PD_ACC_HI
    } t_prod_dst;

    typedef struct packed {
        logic      store_we;
        logic      capture;
        t_mul_sel  mul_sel;
        t_prod_dst prod_dst;
        logic      diff;
        logic      abs_dist;
        logic      far_chk;
        logic      lod_set;
        logic      vis_init;
        logic      pl_clr;
        logic      pl_inc;
        logic      pl_init;
        logic      pl_check;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic pl_last;
        logic upd;
    } t_status;

endpackage

`default_nettype wire

// File: rtl/core/fbcl_ctrl.sv
// ============================================================================
// fbcl_ctrl: sequencing controller
// Walks one test transaction through the shared multiplier schedule and
// issues datapath commands; plane loads are written straight from idle.
// ============================================================================
`default_nettype none

module fbcl_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_s_tvalid,
    input  wire             i_s_tuser,
    output logic            o_s_tready,
    input  wire fbcl_pkg::t_status i_status,
    output fbcl_pkg::t_cmd  o_cmd
);

    fbcl_pkg::t_state r_state;
    fbcl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbcl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fbcl_pkg::ST_IDLE: begin
                if (i_s_tvalid && (i_s_tuser == fbcl_pkg::OP_TEST)) begin
                    n_state = fbcl_pkg::ST_MINX;
                end
            end
            fbcl_pkg::ST_MINX:   n_state = fbcl_pkg::ST_MINZ;
            fbcl_pkg::ST_MINZ:   n_state = fbcl_pkg::ST_SS;
            fbcl_pkg::ST_SS:     n_state = fbcl_pkg::ST_DIFF;
            fbcl_pkg::ST_DIFF:   n_state = fbcl_pkg::ST_ABS;
            fbcl_pkg::ST_ABS:    n_state = fbcl_pkg::ST_DX2;
            fbcl_pkg::ST_DX2:    n_state = fbcl_pkg::ST_DZ2;
            fbcl_pkg::ST_DZ2:    n_state = fbcl_pkg::ST_D2;
            fbcl_pkg::ST_D2:     n_state = fbcl_pkg::ST_LOD;
            fbcl_pkg::ST_LOD: begin
                n_state = i_status.upd ? fbcl_pkg::ST_PL_XL : fbcl_pkg::ST_DONE;
            end
            fbcl_pkg::ST_PL_XL:  n_state = fbcl_pkg::ST_PL_XH;
            fbcl_pkg::ST_PL_XH:  n_state = fbcl_pkg::ST_PL_ZL;
            fbcl_pkg::ST_PL_ZL:  n_state = fbcl_pkg::ST_PL_ZH;
            fbcl_pkg::ST_PL_ZH:  n_state = fbcl_pkg::ST_PL_END;
            fbcl_pkg::ST_PL_END: n_state = fbcl_pkg::ST_PL_CHK;
            fbcl_pkg::ST_PL_CHK: begin
                n_state = i_status.pl_last ? fbcl_pkg::ST_DONE : fbcl_pkg::ST_PL_XL;
            end
            fbcl_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = fbcl_pkg::ST_IDLE;
                end
            end
            default:             n_state = fbcl_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            fbcl_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.store_we = (i_s_tuser == fbcl_pkg::OP_LOAD);
                    o_cmd.capture  = (i_s_tuser == fbcl_pkg::OP_TEST);
                end
            end
            fbcl_pkg::ST_MINX: begin
                o_cmd.mul_sel = fbcl_pkg::MS_CXS;
            end
            fbcl_pkg::ST_MINZ: begin
                o_cmd.mul_sel  = fbcl_pkg::MS_CZS;
                o_cmd.prod_dst = fbcl_pkg::PD_MINX;
            end
            fbcl_pkg::ST_SS: begin
                o_cmd.mul_sel  = fbcl_pkg::MS_SS;
                o_cmd.prod_dst = fbcl_pkg::PD_MINZ;
            end
            fbcl_pkg::ST_DIFF: begin
                o_cmd.prod_dst = fbcl_pkg::PD_SS;
                o_cmd.diff     = 1'b1;
            end
            fbcl_pkg::ST_ABS: begin
                o_cmd.abs_dist = 1'b1;
            end
            fbcl_pkg::ST_DX2: begin
                o_cmd.mul_sel = fbcl_pkg::MS_DX2;
                o_cmd.far_chk = 1'b1;
            end
            fbcl_pkg::ST_DZ2: begin
                o_cmd.mul_sel  = fbcl_pkg::MS_DZ2;
                o_cmd.prod_dst = fbcl_pkg::PD_D2_SET;
            end
            fbcl_pkg::ST_D2: begin
                o_cmd.prod_dst = fbcl_pkg::PD_D2_ADD;
            end
            fbcl_pkg::ST_LOD: begin
                o_cmd.lod_set  = 1'b1;
                o_cmd.vis_init = 1'b1;
                o_cmd.pl_clr   = 1'b1;
            end
            fbcl_pkg::ST_PL_XL: begin
                o_cmd.mul_sel = fbcl_pkg::MS_XL;
                o_cmd.pl_init = 1'b1;
            end
            fbcl_pkg::ST_PL_XH: begin
                o_cmd.mul_sel  = fbcl_pkg::MS_XH;
                o_cmd.prod_dst = fbcl_pkg::PD_ACC_LO;
            end
            fbcl_pkg::ST_PL_ZL: begin
                o_cmd.mul_sel  = fbcl_pkg::MS_ZL;
                o_cmd.prod_dst = fbcl_pkg::PD_ACC_HI;
            end
            fbcl_pkg::ST_PL_ZH: begin
                o_cmd.mul_sel  = fbcl_pkg::MS_ZH;
                o_cmd.prod_dst = fbcl_pkg::PD_ACC_LO;
            end
            fbcl_pkg::ST_PL_END: begin
                o_cmd.prod_dst = fbcl_pkg::PD_ACC_HI;
            end
            fbcl_pkg::ST_PL_CHK: begin
                o_cmd.pl_check = 1'b1;
                o_cmd.pl_inc   = !i_status.pl_last;
            end
            fbcl_pkg::ST_DONE: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/fbcl_dp.sv
// ============================================================================
// fbcl_dp: datapath for the frustum cull and LOD block
// Plane store, chunk size register, one shared 26x26 signed multiplier with
// a registered product, distance and plane accumulators, output register.
// ============================================================================
`default_nettype none

module fbcl_dp #(
    parameter int NUM_PLANES = 6
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [fbcl_pkg::SIZE_W-1:0]        i_cfg_wdata,
    input  wire  [fbcl_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    input  wire fbcl_pkg::t_cmd                i_cmd,
    output fbcl_pkg::t_status                  o_status,
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    output logic [fbcl_pkg::LOD_W-1:0]         o_lod,
    output logic                               o_visible,
    output logic                               o_tested
);

    localparam int PW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    localparam int SIZE_W  = fbcl_pkg::SIZE_W;
    localparam int COORD_W = fbcl_pkg::COORD_W;
    localparam int POS_W   = fbcl_pkg::POS_W;
    localparam int NRM_W   = fbcl_pkg::NRM_W;
    localparam int OFF_W   = fbcl_pkg::OFF_W;
    localparam int IDX_W   = fbcl_pkg::IDX_W;
    localparam int MIN_W   = fbcl_pkg::MIN_W;
    localparam int DIFF_W  = fbcl_pkg::DIFF_W;
    localparam int ABS_W   = fbcl_pkg::ABS_W;
    localparam int NEAR_W  = fbcl_pkg::NEAR_W;
    localparam int MUL_W   = fbcl_pkg::MUL_W;
    localparam int PROD_W  = fbcl_pkg::PROD_W;
    localparam int SS_W    = fbcl_pkg::SS_W;
    localparam int D2_W    = fbcl_pkg::D2_W;
    localparam int ACC_W   = fbcl_pkg::ACC_W;
    localparam int SPLIT   = fbcl_pkg::SPLIT;

    // Input fields.
    logic        [IDX_W-1:0]   in_idx;
    logic signed [NRM_W-1:0]   in_nx, in_ny, in_nz;
    logic signed [OFF_W-1:0]   in_off;
    logic signed [COORD_W-1:0] in_cx, in_cz;
    logic signed [POS_W-1:0]   in_camx, in_camz;
    logic                      in_upd;
    logic                      idx_ok;

    assign in_idx  = i_s_tdata[fbcl_pkg::F_IDX_LSB +: IDX_W];
    assign in_nx   = i_s_tdata[fbcl_pkg::F_NX_LSB +: NRM_W];
    assign in_ny   = i_s_tdata[fbcl_pkg::F_NY_LSB +: NRM_W];
    assign in_nz   = i_s_tdata[fbcl_pkg::F_NZ_LSB +: NRM_W];
    assign in_off  = i_s_tdata[fbcl_pkg::F_OFF_LSB +: OFF_W];
    assign in_cx   = i_s_tdata[fbcl_pkg::F_CX_LSB +: COORD_W];
    assign in_cz   = i_s_tdata[fbcl_pkg::F_CZ_LSB +: COORD_W];
    assign in_camx = i_s_tdata[fbcl_pkg::F_CAMX_LSB +: POS_W];
    assign in_camz = i_s_tdata[fbcl_pkg::F_CAMZ_LSB +: POS_W];
    assign in_upd  = i_s_tdata[fbcl_pkg::F_UPD_LSB];
    assign idx_ok  = ((IDX_W+1)'(in_idx) < (IDX_W+1)'(NUM_PLANES));

    // Control and architectural state.
    logic        [SIZE_W-1:0] r_size;
    logic signed [NRM_W-1:0]  r_pnx  [NUM_PLANES];
    logic signed [NRM_W-1:0]  r_pny  [NUM_PLANES];
    logic signed [NRM_W-1:0]  r_pnz  [NUM_PLANES];
    logic signed [OFF_W-1:0]  r_poff [NUM_PLANES];
    logic        [PW-1:0]     r_pidx;
    logic                     r_ovalid;

    // Working registers.
    logic signed [COORD_W-1:0] r_cx, r_cz;
    logic signed [POS_W-1:0]   r_camx, r_camz;
    logic                      r_upd;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [MIN_W-1:0]   r_minx, r_minz, r_maxx, r_maxz;
    logic signed [DIFF_W-1:0]  r_dx, r_dz;
    logic        [ABS_W-1:0]   r_adx, r_adz;
    logic        [SS_W-1:0]    r_ss;
    logic        [D2_W-1:0]    r_d2;
    logic                      r_far;
    logic [fbcl_pkg::LOD_W-1:0] r_lod;
    logic                      r_vis;
    logic signed [ACC_W-1:0]   r_acc;
    logic [fbcl_pkg::LOD_W-1:0] r_olod;
    logic                      r_ovis;
    logic                      r_otested;

    // Current plane.
    logic signed [NRM_W-1:0] rd_nx, rd_ny, rd_nz;
    logic signed [OFF_W-1:0] rd_off;
    logic signed [MIN_W-1:0] sel_x, sel_z;

    assign rd_nx  = r_pnx[r_pidx];
    assign rd_ny  = r_pny[r_pidx];
    assign rd_nz  = r_pnz[r_pidx];
    assign rd_off = r_poff[r_pidx];

    // Positive vertex: far box face along a non-negative normal component.
    assign sel_x = rd_nx[NRM_W-1] ? r_minx : r_maxx;
    assign sel_z = rd_nz[NRM_W-1] ? r_minz : r_maxz;

    // Shared multiplier operands.
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] n_prod;
    logic        [MUL_W-1:0]  size_op;

    assign size_op = {{(MUL_W-SIZE_W){1'b0}}, r_size};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_sel)
            fbcl_pkg::MS_NONE: begin
                mul_a = '0;
                mul_b = '0;
            end
            fbcl_pkg::MS_CXS: begin
                mul_a = {{(MUL_W-COORD_W){r_cx[COORD_W-1]}}, r_cx};
                mul_b = size_op;
            end
            fbcl_pkg::MS_CZS: begin
                mul_a = {{(MUL_W-COORD_W){r_cz[COORD_W-1]}}, r_cz};
                mul_b = size_op;
            end
            fbcl_pkg::MS_SS: begin
                mul_a = size_op;
                mul_b = size_op;
            end
            fbcl_pkg::MS_DX2: begin
                mul_a = {{(MUL_W-NEAR_W){1'b0}}, r_adx[NEAR_W-1:0]};
                mul_b = {{(MUL_W-NEAR_W){1'b0}}, r_adx[NEAR_W-1:0]};
            end
            fbcl_pkg::MS_DZ2: begin
                mul_a = {{(MUL_W-NEAR_W){1'b0}}, r_adz[NEAR_W-1:0]};
                mul_b = {{(MUL_W-NEAR_W){1'b0}}, r_adz[NEAR_W-1:0]};
            end
            fbcl_pkg::MS_XL: begin
                mul_a = {{(MUL_W-NRM_W){rd_nx[NRM_W-1]}}, rd_nx};
                mul_b = {{(MUL_W-SPLIT){1'b0}}, sel_x[SPLIT-1:0]};
            end
            fbcl_pkg::MS_XH: begin
                mul_a = {{(MUL_W-NRM_W){rd_nx[NRM_W-1]}}, rd_nx};
                mul_b = {{(MUL_W-MIN_W+SPLIT){sel_x[MIN_W-1]}}, sel_x[MIN_W-1:SPLIT]};
            end
            fbcl_pkg::MS_ZL: begin
                mul_a = {{(MUL_W-NRM_W){rd_nz[NRM_W-1]}}, rd_nz};
                mul_b = {{(MUL_W-SPLIT){1'b0}}, sel_z[SPLIT-1:0]};
            end
            fbcl_pkg::MS_ZH: begin
                mul_a = {{(MUL_W-NRM_W){rd_nz[NRM_W-1]}}, rd_nz};
                mul_b = {{(MUL_W-MIN_W+SPLIT){sel_z[MIN_W-1]}}, sel_z[MIN_W-1:SPLIT]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign n_prod = mul_a * mul_b;

    // Derived terms.
    logic signed [DIFF_W-1:0] neg_dx, neg_dz;
    logic        [ABS_W-1:0]  far_lim;
    logic        [D2_W-1:0]   lim_near, lim_mid;
    logic signed [ACC_W-1:0]  off_term, ny_term, prod_lo, prod_hi;

    assign neg_dx   = -r_dx;
    assign neg_dz   = -r_dz;
    assign far_lim  = {{(ABS_W-SIZE_W-2){1'b0}}, r_size, 2'b00};
    assign lim_near = {{(D2_W-SS_W-2){1'b0}}, r_ss, 2'b00};
    assign lim_mid  = {{(D2_W-SS_W-4){1'b0}}, r_ss, 4'b0000};
    assign off_term = {{(ACC_W-OFF_W-fbcl_pkg::OFF_SH){rd_off[OFF_W-1]}}, rd_off,
                       {fbcl_pkg::OFF_SH{1'b0}}};
    assign ny_term  = rd_ny[NRM_W-1] ? '0 :
                      {{(ACC_W-NRM_W-fbcl_pkg::BOX_TOP_SH){1'b0}}, rd_ny,
                       {fbcl_pkg::BOX_TOP_SH{1'b0}}};
    assign prod_lo  = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign prod_hi  = {r_prod[ACC_W-SPLIT-1:0], {SPLIT{1'b0}}};

    // State with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= fbcl_pkg::SIZE_RESET;
            r_pidx   <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < NUM_PLANES; i++) begin
                r_pnx[i]  <= '0;
                r_pny[i]  <= '0;
                r_pnz[i]  <= '0;
                r_poff[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            if (i_cmd.store_we && idx_ok) begin
                r_pnx[in_idx[PW-1:0]]  <= in_nx;
                r_pny[in_idx[PW-1:0]]  <= in_ny;
                r_pnz[in_idx[PW-1:0]]  <= in_nz;
                r_poff[in_idx[PW-1:0]] <= in_off;
            end
            if (i_cmd.pl_clr) begin
                r_pidx <= '0;
            end else if (i_cmd.pl_inc) begin
                r_pidx <= r_pidx + PW'(1);
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (i_cmd.capture) begin
            r_cx   <= in_cx;
            r_cz   <= in_cz;
            r_camx <= in_camx;
            r_camz <= in_camz;
            r_upd  <= in_upd;
        end
        unique case (i_cmd.prod_dst)
            fbcl_pkg::PD_NONE:   ;
            fbcl_pkg::PD_MINX:   r_minx <= r_prod[MIN_W-1:0];
            fbcl_pkg::PD_MINZ:   r_minz <= r_prod[MIN_W-1:0];
            fbcl_pkg::PD_SS:     r_ss   <= r_prod[SS_W-1:0];
            fbcl_pkg::PD_D2_SET: r_d2   <= r_prod[D2_W-1:0];
            fbcl_pkg::PD_D2_ADD: r_d2   <= r_d2 + r_prod[D2_W-1:0];
            fbcl_pkg::PD_ACC_LO: r_acc  <= r_acc + prod_lo;
            fbcl_pkg::PD_ACC_HI: r_acc  <= r_acc + prod_hi;
            default:             ;
        endcase
        if (i_cmd.pl_init) begin
            r_acc <= off_term + ny_term;
        end
        if (i_cmd.diff) begin
            r_dx   <= {{(DIFF_W-POS_W){r_camx[POS_W-1]}}, r_camx}
                      - {r_minx[MIN_W-1], r_minx};
            r_dz   <= {{(DIFF_W-POS_W){r_camz[POS_W-1]}}, r_camz}
                      - {r_minz[MIN_W-1], r_minz};
            r_maxx <= r_minx + {{(MIN_W-SIZE_W){1'b0}}, r_size};
            r_maxz <= r_minz + {{(MIN_W-SIZE_W){1'b0}}, r_size};
        end
        if (i_cmd.abs_dist) begin
            r_adx <= r_dx[DIFF_W-1] ? neg_dx[ABS_W-1:0] : r_dx[ABS_W-1:0];
            r_adz <= r_dz[DIFF_W-1] ? neg_dz[ABS_W-1:0] : r_dz[ABS_W-1:0];
        end
        if (i_cmd.far_chk) begin
            r_far <= (r_adx >= far_lim) || (r_adz >= far_lim);
        end
        if (i_cmd.lod_set) begin
            priority if (r_far) begin
                r_lod <= fbcl_pkg::LOD_FAR;
            end else if (r_d2 < lim_near) begin
                r_lod <= fbcl_pkg::LOD_NEAR;
            end else if (r_d2 < lim_mid) begin
                r_lod <= fbcl_pkg::LOD_MID;
            end else begin
                r_lod <= fbcl_pkg::LOD_FAR;
            end
        end
        if (i_cmd.vis_init) begin
            r_vis <= r_upd;
        end else if (i_cmd.pl_check && r_acc[ACC_W-1]) begin
            r_vis <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_olod    <= r_lod;
            r_ovis    <= r_vis;
            r_otested <= r_upd;
        end
    end

    assign o_status.out_free = !r_ovalid || i_m_tready;
    assign o_status.pl_last  = (r_pidx == PW'(NUM_PLANES - 1));
    assign o_status.upd      = r_upd;

    assign o_m_tvalid = r_ovalid;
    assign o_lod      = r_olod;
    assign o_visible  = r_ovis;
    assign o_tested   = r_otested;

endmodule

`default_nettype wire

// File: rtl/core/frustum_box_cull_lod.sv
// ============================================================================
// frustum_box_cull_lod: frustum culling and level-of-detail choice per chunk
// Top level joining the sequencing controller and the arithmetic datapath.
// ============================================================================
//
// Usage. Items arrive on the s_axis stream; tuser selects the operation.
// A plane load (tuser 1) writes one entry of the plane store in the cycle it
// is accepted and produces no result; loads with an index at or beyond
// NUM_PLANES are dropped. A chunk test (tuser 0) produces exactly one result
// transaction on m_axis with the detail level and the visibility flags.
// A test always computes the detail level; the visibility test runs only when
// update_frustum is set. One test is in flight at a time: no new item is
// taken until its result has been handed to the output register. For the
// visibility test, each plane needs four partial products of normal times box
// coordinate from the shared 26x26 multiplier, then a step to finish the sum
// and one to check its sign. The result sits in an output register, so a
// stalled receiver does not block acceptance of the next transaction; only
// the hand-off of a finished result waits for that register to drain. Reset
// clears the plane store and loads the chunk size with 64.0. The chunk size
// is written through i_cfg_we and i_cfg_wdata; the user must do so only while
// no test is in progress, as the block itself does not enforce it.
//
`default_nettype none

module frustum_box_cull_lod #(
    parameter int NUM_PLANES = 6
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Configuration: chunk edge length, unsigned Q15.8.
    input  wire                                 i_cfg_we,
    input  wire  [fbcl_pkg::SIZE_W-1:0]         i_cfg_wdata,
    // Input stream.
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata, lowest bit up: plane_index[3], plane_nx[16], plane_ny[16],
    // plane_nz[16], plane_offset[24], chunk_x[16], chunk_z[16],
    // camera_x[24], camera_z[24], update_frustum[1], zero padding[4].
    input  wire  [fbcl_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: operation[1] (0 test chunk, 1 load plane).
    input  wire                                 s_axis_tuser,
    // Result stream.
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // tdata, lowest bit up: lod_level[2], visible[1], visibility_tested[1],
    // zero padding[4].
    output logic [fbcl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    fbcl_pkg::t_cmd    cmd;
    fbcl_pkg::t_status status;

    logic [fbcl_pkg::LOD_W-1:0] res_lod;
    logic                       res_visible;
    logic                       res_tested;

    // The controller owns sequencing and the input handshake.
    fbcl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tuser  (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath holds the plane store, the multiplier and the output register.
    fbcl_dp #(
        .NUM_PLANES (NUM_PLANES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_lod       (res_lod),
        .o_visible   (res_visible),
        .o_tested    (res_tested)
    );

    // Result fields are packed from bit zero upward with zero padding on top.
    assign m_axis_tdata = {{(fbcl_pkg::OUT_TDATA_W - fbcl_pkg::LOD_W - 2){1'b0}},
                           res_tested, res_visible, res_lod};

endmodule

`default_nettype wire

// File: tb/sv/frustum_box_cull_lod_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// frustum_box_cull_lod_tb: self-checking bench for the frustum cull and LOD block
// Opens with a table of hand-picked plane loads and chunk tests, then runs
// random frames of six plane loads followed by bursts of chunk tests around
// a common center, mixed with random and out-of-range transactions, under
// several chunk sizes. Every result transaction is checked field by field against its
// typed-in expectation or a behavioral predictor of the plane store and the LOD/visibility math.
// ============================================================================

module frustum_box_cull_lod_tb;

    import fbcl_pkg::*;

    localparam int PLANES        = 6;
    localparam int RESET_CYCLES  = 12;
    // Long enough for a visibility test over all planes to finish, with margin.
    localparam int SETTLE_CYCLES = 64;
    localparam int IDLE_PCT      = 26;
    // Box height 32.0 in Q16.8 and the Q16.8 to Q.22 scale of the offset.
    localparam longint BOX_TOP   = 8192;
    localparam longint OFF_SCALE = 16384;

    typedef struct packed {
        logic                op;
        logic [IDX_W-1:0]    idx;
        logic [NRM_W-1:0]    nx;
        logic [NRM_W-1:0]    ny;
        logic [NRM_W-1:0]    nz;
        logic [OFF_W-1:0]    off;
        logic [COORD_W-1:0]  cx;
        logic [COORD_W-1:0]  cz;
        logic [POS_W-1:0]    camx;
        logic [POS_W-1:0]    camz;
        logic                upd;
    } t_chunk_item;

    typedef struct packed {
        logic [LOD_W-1:0] lod;
        logic             visible;
        logic             tested;
    } t_cull_result;

    typedef struct packed {
        t_chunk_item  it;
        logic         typed;
        t_cull_result want;
    } t_stim_row;

    // DUT ports; the inputs are driven to known values from time zero.
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [SIZE_W-1:0]      i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Shadow copy of the chunk size and the plane store.
    logic [SIZE_W-1:0]      size_model = SIZE_RESET;
    logic [NRM_W-1:0]       plane_nx [PLANES];
    logic [NRM_W-1:0]       plane_ny [PLANES];
    logic [NRM_W-1:0]       plane_nz [PLANES];
    logic [OFF_W-1:0]       plane_off[PLANES];

    t_cull_result           awaited_results[$];
    t_stim_row              directed_rows[$];
    int                     errors = 0;
    // While calm is set, neither side inserts idle cycles.
    bit                     calm = 1'b0;

    frustum_box_cull_lod #(
        .NUM_PLANES (PLANES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // Hard stop in case the block hangs.
    initial begin
        #8000000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic longint clampv(input longint v, input int w);
        longint lo;
        longint hi;
        lo = -(longint'(1) <<< (w - 1));
        hi = -lo - 1;
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Uniform value in [-a, a].
    function automatic longint spread(input longint a);
        return longint'($urandom_range(0, 32'(2 * a))) - a;
    endfunction

    // Expected detail level and visibility of one chunk test, computed in
    // 64-bit arithmetic wide enough that nothing wraps.
    function automatic t_cull_result judge_chunk(input t_chunk_item it);
        t_cull_result r;
        longint s, minx, minz, maxx, maxz, dx, dz, d2, d, nx, ny, nz;
        s    = longint'(size_model);
        minx = longint'($signed(it.cx)) * s;
        minz = longint'($signed(it.cz)) * s;
        maxx = minx + s;
        maxz = minz + s;
        dx   = longint'($signed(it.camx)) - minx;
        dz   = longint'($signed(it.camz)) - minz;
        if (dx < 0) dx = -dx;
        if (dz < 0) dz = -dz;

        // Compare squared distance with (2*size)^2 and (4*size)^2; a single
        // axis at or beyond 4*size is far without squaring.
        if (dx >= 4 * s || dz >= 4 * s) begin
            r.lod = LOD_FAR;
        end else begin
            d2 = dx * dx + dz * dz;
            if (d2 < 4 * s * s) r.lod = LOD_NEAR;
            else if (d2 < 16 * s * s) r.lod = LOD_MID;
            else r.lod = LOD_FAR;
        end

        r.visible = 1'b0;
        r.tested  = 1'b0;
        if (it.upd) begin
            r.tested  = 1'b1;
            r.visible = 1'b1;
            // Positive vertex per plane: the box corner furthest along the normal.
            for (int p = 0; p < PLANES; p++) begin
                nx = longint'($signed(plane_nx[p]));
                ny = longint'($signed(plane_ny[p]));
                nz = longint'($signed(plane_nz[p]));
                d  = nx * ((nx >= 0) ? maxx : minx)
                   + ny * ((ny >= 0) ? BOX_TOP : 0)
                   + nz * ((nz >= 0) ? maxz : minz)
                   + longint'($signed(plane_off[p])) * OFF_SCALE;
                if (d < 0) r.visible = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_fields(input t_chunk_item it);
        logic [IN_TDATA_W-1:0] t;
        t = '0;
        t[F_IDX_LSB  +: IDX_W]   = it.idx;
        t[F_NX_LSB   +: NRM_W]   = it.nx;
        t[F_NY_LSB   +: NRM_W]   = it.ny;
        t[F_NZ_LSB   +: NRM_W]   = it.nz;
        t[F_OFF_LSB  +: OFF_W]   = it.off;
        t[F_CX_LSB   +: COORD_W] = it.cx;
        t[F_CZ_LSB   +: COORD_W] = it.cz;
        t[F_CAMX_LSB +: POS_W]   = it.camx;
        t[F_CAMZ_LSB +: POS_W]   = it.camz;
        t[F_UPD_LSB]             = it.upd;
        return t;
    endfunction

    // Presents one transaction, starting and ending at a falling edge. Valid is
    // left high so back-to-back transactions need no idle gap. On acceptance
    // a load updates the shadow store and a test queues its expected result,
    // either the typed-in one or the predicted one.
    task automatic send_item(input t_chunk_item it, input logic typed,
                             input t_cull_result want);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = pack_fields(it);
        s_axis_tuser  = it.op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (it.op == OP_LOAD) begin
            if (it.idx < PLANES) begin
                plane_nx[it.idx]  = it.nx;
                plane_ny[it.idx]  = it.ny;
                plane_nz[it.idx]  = it.nz;
                plane_off[it.idx] = it.off;
            end
        end else begin
            awaited_results.insert(awaited_results.size(),
                                   typed ? want : judge_chunk(it));
        end
        @(negedge i_clk);
    endtask

    // Holds the sender off until every expected result has come back and the
    // block has had time to finish any test still in flight.
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_chunk_size(input logic [SIZE_W-1:0] v);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        size_model  = v;
    endtask

    task automatic add_row(input logic op, input int idx, input int nx, input int ny,
                           input int nz, input int off, input int cx, input int cz,
                           input int camx, input int camz, input logic upd,
                           input logic typed, input logic [LOD_W-1:0] lod,
                           input logic vis, input logic tst);
        t_stim_row r;
        r.it.op   = op;
        r.it.idx  = IDX_W'(idx);
        r.it.nx   = NRM_W'(nx);
        r.it.ny   = NRM_W'(ny);
        r.it.nz   = NRM_W'(nz);
        r.it.off  = OFF_W'(off);
        r.it.cx   = COORD_W'(cx);
        r.it.cz   = COORD_W'(cz);
        r.it.camx = POS_W'(camx);
        r.it.camz = POS_W'(camz);
        r.it.upd  = upd;
        r.typed   = typed;
        r.want    = {lod, vis, tst};
        directed_rows.insert(directed_rows.size(), r);
    endtask

    // Random traffic. Most of it is frames: six planes that all face a common
    // center, followed by chunk tests around that center with the camera a few
    // chunk lengths away, so that culled and visible chunks and all three
    // detail levels show up. The rest is fully random transactions and loads
    // to plane slots that do not exist; the latter do not count.
    task automatic run_phase(input int count);
        int          sent;
        int          roll;
        longint      s, lim, cen_x, cen_z, k, qx, qy, qz, nx, ny, nz;
        t_chunk_item it;
        sent = 0;
        while (sent < count) begin
            roll = $urandom_range(0, 99);
            s    = longint'(size_model);
            if (roll < 80) begin
                lim   = (30000 * s < (longint'(1) << 22)) ? 30000 * s : (longint'(1) << 22);
                cen_x = spread(lim);
                cen_z = spread(lim);
                for (int p = 0; p < PLANES; p++) begin
                    it     = '0;
                    it.op  = OP_LOAD;
                    it.idx = IDX_W'(p);
                    it.nx  = NRM_W'($urandom);
                    it.ny  = NRM_W'($urandom);
                    it.nz  = NRM_W'($urandom);
                    nx     = longint'($signed(it.nx));
                    ny     = longint'($signed(it.ny));
                    nz     = longint'($signed(it.nz));
                    // The plane passes through a point set back from the
                    // center against its normal, so the center lies in front.
                    k      = longint'($urandom_range(0, 32'(4 * s)));
                    qx     = cen_x - ((nx * k) >>> 14);
                    qy     = 4096 - ((ny * k) >>> 14);
                    qz     = cen_z - ((nz * k) >>> 14);
                    it.off = OFF_W'(clampv(-((nx * qx + ny * qy + nz * qz) >>> 14), OFF_W));
                    send_item(it, 1'b0, '0);
                    sent++;
                end
                repeat ($urandom_range(4, 16)) begin
                    it      = '0;
                    it.op   = OP_TEST;
                    it.cx   = COORD_W'(clampv(cen_x / s + spread(3), COORD_W));
                    it.cz   = COORD_W'(clampv(cen_z / s + spread(3), COORD_W));
                    it.camx = POS_W'(clampv(longint'($signed(it.cx)) * s + spread(5 * s),
                                            POS_W));
                    it.camz = POS_W'(clampv(longint'($signed(it.cz)) * s + spread(5 * s),
                                            POS_W));
                    it.upd  = ($urandom_range(0, 9) != 0);
                    send_item(it, 1'b0, '0);
                    sent++;
                end
            end else if (roll < 92) begin
                it.op   = 1'($urandom);
                it.idx  = IDX_W'($urandom);
                it.nx   = NRM_W'($urandom);
                it.ny   = NRM_W'($urandom);
                it.nz   = NRM_W'($urandom);
                it.off  = OFF_W'($urandom);
                it.cx   = COORD_W'($urandom);
                it.cz   = COORD_W'($urandom);
                it.camx = POS_W'($urandom);
                it.camz = POS_W'($urandom);
                it.upd  = 1'($urandom);
                send_item(it, 1'b0, '0);
                if (!(it.op == OP_LOAD && it.idx >= PLANES)) sent++;
            end else begin
                it      = '0;
                it.op   = OP_LOAD;
                it.idx  = IDX_W'($urandom_range(PLANES, 7));
                it.nx   = NRM_W'($urandom);
                it.ny   = NRM_W'($urandom);
                it.nz   = NRM_W'($urandom);
                it.off  = OFF_W'($urandom);
                send_item(it, 1'b0, '0);
            end
        end
    endtask

    // Receiver: random back-pressure, and a field-by-field check of every
    // result transaction against the oldest expectation.
    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_cull_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result transaction %h", m_axis_tdata));
            end else begin
                want = awaited_results.pop_front();
                if (m_axis_tdata[1:0] !== want.lod)
                    report_mismatch($sformatf("lod_level %0d, expected %0d",
                                              m_axis_tdata[1:0], want.lod));
                if (m_axis_tdata[2] !== want.visible)
                    report_mismatch($sformatf("visible %0b, expected %0b",
                                              m_axis_tdata[2], want.visible));
                if (m_axis_tdata[3] !== want.tested)
                    report_mismatch($sformatf("visibility_tested %0b, expected %0b",
                                              m_axis_tdata[3], want.tested));
            end
        end
    end

    initial begin
        logic [SIZE_W-1:0] sizes[6];
        for (int p = 0; p < PLANES; p++) begin
            plane_nx[p]  = '0;
            plane_ny[p]  = '0;
            plane_nz[p]  = '0;
            plane_off[p] = '0;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed table, chunk size 64.0 from reset. Typed rows follow from
        // the cleared plane store or from plain distance boundaries.
        //      op       idx  nx      ny      nz      off       cx      cz      camx      camz     upd
        // Cleared planes pass everything.
        add_row(OP_TEST, 0,   0,      0,      0,      0,        0,      0,      0,        0,       1,
                1, LOD_NEAR, 1, 1);
        // Test skipped: no visibility, but the level is still computed.
        add_row(OP_TEST, 0,   0,      0,      0,      0,        0,      0,      0,        0,       0,
                1, LOD_NEAR, 0, 0);
        // Extreme coordinates and camera positions.
        add_row(OP_TEST, 0,   0,      0,      0,      0,        32767,  -32768, -8388608, 8388607, 1,
                1, LOD_FAR, 1, 1);
        add_row(OP_TEST, 0,   0,      0,      0,      0,        -32768, 32767,  8388607, -8388608, 0,
                1, LOD_FAR, 0, 0);
        // Distance boundaries around 2*size and 4*size.
        add_row(OP_TEST, 0,   0,      0,      0,      0,        0,      0,      49152,    0,       0,
                1, LOD_MID, 0, 0);
        add_row(OP_TEST, 0,   0,      0,      0,      0,        0,      0,      32768,    0,       0,
                1, LOD_MID, 0, 0);
        add_row(OP_TEST, 0,   0,      0,      0,      0,        0,      0,      32767,    0,       0,
                1, LOD_NEAR, 0, 0);
        add_row(OP_TEST, 0,   0,      0,      0,      0,        0,      0,      65536,    0,       0,
                1, LOD_FAR, 0, 0);
        add_row(OP_TEST, 0,   0,      0,      0,      0,        0,      0,      -65535,   0,       0,
                1, LOD_MID, 0, 0);
        // Loads to slots past the last plane are dropped.
        add_row(OP_LOAD, 6,   -32768, -32768, -32768, -8388608, 0,      0,      0,        0,       0,
                0, LOD_NEAR, 0, 0);
        add_row(OP_LOAD, 7,   -32768, -32768, -32768, -8388608, 0,      0,      0,        0,       0,
                0, LOD_NEAR, 0, 0);
        add_row(OP_TEST, 0,   0,      0,      0,      0,        0,      0,      0,        0,       1,
                1, LOD_NEAR, 1, 1);
        // A plane x <= 0, then chunks on both sides of it.
        add_row(OP_LOAD, 0,   -32768, 0,      0,      0,        0,      0,      0,        0,       0,
                0, LOD_NEAR, 0, 0);
        add_row(OP_TEST, 0,   0,      0,      0,      0,        0,      0,      0,        0,       1,
                0, LOD_NEAR, 0, 0);
        add_row(OP_TEST, 0,   0,      0,      0,      0,        1,      0,      0,        0,       1,
                0, LOD_NEAR, 0, 0);
        add_row(OP_TEST, 0,   0,      0,      0,      0,        -1,     0,      0,        0,       1,
                0, LOD_NEAR, 0, 0);
        // Extreme normals and offsets in the other slots.
        add_row(OP_LOAD, 5,   32767,  -32768, 32767,  8388607,  0,      0,      0,        0,       0,
                0, LOD_NEAR, 0, 0);
        add_row(OP_LOAD, 1,   0,      32767,  -32768, -8388608, 0,      0,      0,        0,       0,
                0, LOD_NEAR, 0, 0);
        add_row(OP_TEST, 0,   0,      0,      0,      0,        -32768, 32767,  -8388608, 8388607, 1,
                0, LOD_NEAR, 0, 0);
        add_row(OP_TEST, 0,   0,      0,      0,      0,        -1,     -1,     -100,     -100,    1,
                0, LOD_NEAR, 0, 0);
        add_row(OP_LOAD, 2,   1,      1,      1,      0,        0,      0,      0,        0,       0,
                0, LOD_NEAR, 0, 0);
        add_row(OP_LOAD, 1,   0,      0,      0,      0,        0,      0,      0,        0,       0,
                0, LOD_NEAR, 0, 0);
        add_row(OP_TEST, 0,   0,      0,      0,      0,        -1,     5,      -5000,    90000,   1,
                0, LOD_NEAR, 0, 0);
        add_row(OP_TEST, 0,   0,      0,      0,      0,        -1,     5,      -5000,    90000,   0,
                0, LOD_NEAR, 0, 0);
        foreach (directed_rows[i])
            send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);

        // Random phases, each under its own chunk size; the size only changes
        // once the block has gone quiet.
        sizes[0] = 23'd1;
        sizes[1] = SIZE_W'($urandom_range(2, 8388606));
        sizes[2] = 23'd8388607;
        sizes[3] = 23'd256;
        sizes[4] = SIZE_W'($urandom_range(1, 65536));
        sizes[5] = SIZE_RESET;
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_chunk_size(sizes[ph]);
            calm = (ph == 3);
            if (ph == 1) begin
                // Let the pipeline empty completely in the middle of a phase.
                run_phase(80);
                drain();
                run_phase(75);
            end else begin
                run_phase(155);
            end
        end
        calm = 1'b0;
        drain();

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/fbcl_pkg.sv
rtl/core/fbcl_ctrl.sv
rtl/core/fbcl_dp.sv
rtl/core/frustum_box_cull_lod.sv
tb/sv/frustum_box_cull_lod_tb.sv
